// ===== hdl/gcct_pkg.sv =====
// gcct_pkg: shared types and constants of the group cover constraint tracker
// field widths, function codes and count limits; no dependencies

package gcct_pkg;

    localparam int FUNC_W   = 3;
    localparam int DIM_W    = 2;
    localparam int ITEM_W   = 8;
    localparam int MASK_W   = 4;
    localparam int GROUP_W  = 2;
    localparam int RATIO_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_MEMBER = 3'd0,
        FUNC_LOAD_RATIO  = 3'd1,
        FUNC_LOAD_MAX    = 3'd2,
        FUNC_SET_PRESENT = 3'd3,
        FUNC_SET_ABSENT  = 3'd4
    } func_t;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [RATIO_W-1:0] ratio_t;

endpackage

// ===== hdl/group_cover_constraint_tracker.sv =====
// group_cover_constraint_tracker: membership store, per-group counters and constraint check
// depends on gcct_pkg
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_ready, func .. size_limit    | into block
//  out      | out_valid, out_ready, satisfied           | out of block
//
// one word is accepted per cycle while the output is not stalled; each accepted word passes through
// the membership read from the synchronous store, then the counter update, then the check.
// after reset a clearing pass zeroes the store, with in_ready low throughout.
// a stalled output holds the check stage; in_ready drops only once that stage is full too.

module group_cover_constraint_tracker #(
    parameter int GROUPS     = 4,
    parameter int DIMENSIONS = 4,
    parameter int ITEMS      = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gcct_pkg::FUNC_W-1:0]   func,
    input  logic [gcct_pkg::DIM_W-1:0]    dimension,
    input  logic [gcct_pkg::ITEM_W-1:0]   item,
    input  logic [gcct_pkg::MASK_W-1:0]   group_mask,
    input  logic [gcct_pkg::GROUP_W-1:0]  row_group,
    input  logic [gcct_pkg::GROUP_W-1:0]  column_group,
    input  logic [gcct_pkg::RATIO_W-1:0]  ratio_value,
    input  logic [gcct_pkg::COUNT_W-1:0]  size_limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          satisfied
);

    import gcct_pkg::*;

    localparam int DEPTH  = DIMENSIONS * ITEMS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam int PROD_W = RATIO_W + COUNT_W;

    typedef logic [GROUPS-1:0] word_t;

    // membership store
    word_t mem [DEPTH];

    logic                clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;

    // handshake and pipeline control
    logic accept, stall, s1_commit;
    logic s1_valid_reg, s1_valid_next;
    logic chk_valid_reg, chk_valid_next;
    logic out_valid_reg, out_valid_next;
    logic satisfied_reg, satisfied_next;

    // input decode
    logic [ADDR_W-1:0]            in_addr;
    logic                         in_addr_ok;
    logic [GROUPS+MASK_W-1:0]     mask_wide;

    // stage 1 payload
    func_t                 s1_func_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic                  s1_addr_ok_reg;
    word_t                 s1_mask_reg;
    logic [GROUP_W-1:0]    s1_row_reg;
    logic [GROUP_W-1:0]    s1_col_reg;
    ratio_t                s1_ratio_reg;
    count_t                s1_limit_reg;
    word_t                 rd_word_reg;
    logic                  fwd_hit_reg;
    word_t                 fwd_word_reg;

    word_t                 cur_word, new_word, fresh;
    logic                  s1_we;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    word_t                 mem_wdata;

    // group state
    count_t present_reg   [GROUPS];
    count_t present_next  [GROUPS];
    count_t potential_reg [GROUPS];
    count_t potential_next[GROUPS];
    count_t max_reg       [GROUPS];
    count_t max_next      [GROUPS];
    ratio_t ratio_reg     [GROUPS][GROUPS];
    ratio_t ratio_next    [GROUPS][GROUPS];

    assign accept    = in_valid && in_ready;
    assign stall     = chk_valid_reg && out_valid_reg && !out_ready;
    assign in_ready  = !stall && !clr_active_reg;
    assign s1_commit = s1_valid_reg && !stall;
    assign out_valid = out_valid_reg;
    assign satisfied = satisfied_reg;

    assign in_addr    = ADDR_W'(int'(dimension) * ITEMS + int'(item));
    assign in_addr_ok = (int'(dimension) < DIMENSIONS) && (int'(item) < ITEMS);
    assign mask_wide  = (GROUPS + MASK_W)'(group_mask);

    // the word written on the edge a new word is read must be forwarded
    assign cur_word = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
    assign new_word = cur_word | s1_mask_reg;
    assign fresh    = s1_mask_reg & ~cur_word;
    assign s1_we    = (s1_func_reg == FUNC_LOAD_MEMBER) && s1_addr_ok_reg;

    assign mem_we    = clr_active_reg || (s1_commit && s1_we);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = clr_active_reg ? '0 : new_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_word_reg <= mem[in_addr];
        end
    end

    // clearing pass
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_LAST)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // pipeline valids
    always_comb
    begin
        s1_valid_next  = stall ? s1_valid_reg : accept;
        chk_valid_next = stall ? chk_valid_reg : s1_valid_reg;
        if (chk_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
            if (accept)
            begin
                fwd_hit_reg <= s1_commit && s1_we && (s1_addr_reg == in_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg    <= func_t'(func);
            s1_addr_reg    <= in_addr;
            s1_addr_ok_reg <= in_addr_ok;
            s1_mask_reg    <= mask_wide[GROUPS-1:0];
            s1_row_reg     <= row_group;
            s1_col_reg     <= column_group;
            s1_ratio_reg   <= ratio_value;
            s1_limit_reg   <= size_limit;
            fwd_word_reg   <= new_word;
        end
        if (chk_valid_reg && (!out_valid_reg || out_ready))
        begin
            satisfied_reg <= satisfied_next;
        end
    end

    // counter and table updates
    always_comb
    begin
        present_next   = present_reg;
        potential_next = potential_reg;
        max_next       = max_reg;
        ratio_next     = ratio_reg;
        if (s1_commit)
        begin
            case (s1_func_reg)
                FUNC_LOAD_MEMBER:
                begin
                    for (int g = 0; g < GROUPS; g++)
                    begin
                        if (s1_addr_ok_reg && fresh[g] && potential_reg[g] != COUNT_MAX)
                        begin
                            potential_next[g] = potential_reg[g] + 1'b1;
                        end
                    end
                end
                FUNC_LOAD_RATIO:
                begin
                    for (int i = 0; i < GROUPS; i++)
                    begin
                        for (int j = 0; j < GROUPS; j++)
                        begin
                            if (int'(s1_row_reg) == i && int'(s1_col_reg) == j)
                            begin
                                ratio_next[i][j] = s1_ratio_reg;
                            end
                        end
                    end
                end
                FUNC_LOAD_MAX:
                begin
                    for (int g = 0; g < GROUPS; g++)
                    begin
                        if (int'(s1_row_reg) == g)
                        begin
                            max_next[g] = s1_limit_reg;
                        end
                    end
                end
                FUNC_SET_PRESENT:
                begin
                    for (int g = 0; g < GROUPS; g++)
                    begin
                        if (s1_addr_ok_reg && cur_word[g] && present_reg[g] != COUNT_MAX)
                        begin
                            present_next[g] = present_reg[g] + 1'b1;
                        end
                    end
                end
                FUNC_SET_ABSENT:
                begin
                    for (int g = 0; g < GROUPS; g++)
                    begin
                        if (s1_addr_ok_reg && cur_word[g] && potential_reg[g] != '0)
                        begin
                            potential_next[g] = potential_reg[g] - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                present_reg[i]   <= '0;
                potential_reg[i] <= '0;
                max_reg[i]       <= '0;
                for (int j = 0; j < GROUPS; j++)
                begin
                    ratio_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            present_reg   <= present_next;
            potential_reg <= potential_next;
            max_reg       <= max_next;
            ratio_reg     <= ratio_next;
        end
    end

    // constraint check on the state left by the word in the check stage
    always_comb
    begin
        logic [PROD_W-1:0] pot_scaled;
        logic [PROD_W-1:0] need;
        satisfied_next = 1'b1;
        for (int i = 0; i < GROUPS; i++)
        begin
            pot_scaled = PROD_W'({potential_reg[i], FRAC_W'(0)});
            if (present_reg[i] > max_reg[i])
            begin
                satisfied_next = 1'b0;
            end
            for (int j = 0; j < GROUPS; j++)
            begin
                if (i == j)
                begin
                    need = PROD_W'(ratio_reg[i][j]);
                end
                else
                begin
                    need = PROD_W'(ratio_reg[i][j]) * PROD_W'(present_reg[j]);
                end
                if (pot_scaled < need)
                begin
                    satisfied_next = 1'b0;
                end
            end
        end
    end

    // the clearing pass covers the whole store before it ends
    a_clear_span: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_addr_reg) == ADDR_LAST)
        else $error("clearing pass ended early");

    // no word is in flight while the store is being cleared
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s1_valid_reg && !chk_valid_reg && !out_valid_reg))
        else $error("word in flight during clearing");

    // a word held in stage 1 by a stall keeps its address
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && stall) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stage 1 word lost during stall");

    // the check stage only advances into a free output register
    a_chk_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_valid_reg && out_valid_reg && !out_ready) |=> (chk_valid_reg && out_valid_reg))
        else $error("result dropped under back pressure");

endmodule
